FILE: design/lkvc_pkg.sv
// Package for the LRU key-value cache: sizes, operation codes, controller
// state type and the command/status structs between controller and datapath.
// No dependencies.
package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int RANK_W  = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CAP_W   = 5;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic lookup;
        logic commit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_get;
        logic out_stall;
    } dp_sts_t;

endpackage

FILE: design/lkvc_ctrl.sv
// Controller state machine of the LRU key-value cache.
// Depends on lkvc_pkg.
module lkvc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  lkvc_pkg::dp_sts_t sts,
    output lkvc_pkg::dp_cmd_t cmd
);

    lkvc_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lkvc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.lookup  = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            lkvc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = lkvc_pkg::ST_LOOKUP;
                end
            end
            lkvc_pkg::ST_LOOKUP: begin
                cmd.lookup = 1'b1;
                state_next = lkvc_pkg::ST_UPDATE;
            end
            lkvc_pkg::ST_UPDATE: begin
                // A get waits here until the output register can take its result.
                if (!(sts.op_get && sts.out_stall)) begin
                    cmd.commit = 1'b1;
                    state_next = lkvc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lkvc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/lkvc_dp.sv
// Datapath of the LRU key-value cache: entry store, parallel key compare,
// recency ranks, fill count, capacity register and result register.
// Depends on lkvc_pkg.
module lkvc_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]  cfg_wdata,
    input  logic                        in_op,
    input  logic [lkvc_pkg::KEY_W-1:0]  in_key,
    input  logic [lkvc_pkg::VAL_W-1:0]  in_value,
    input  logic                        m_tready,
    output logic                        m_tvalid,
    output logic                        out_hit,
    output logic [lkvc_pkg::VAL_W-1:0]  out_value,
    input  lkvc_pkg::dp_cmd_t           cmd,
    output lkvc_pkg::dp_sts_t           sts
);

    localparam int N = lkvc_pkg::ENTRIES;

    // Capacity register.
    logic [lkvc_pkg::CAP_W-1:0] cap_reg, cap_next;

    // Captured request.
    logic                       op_reg, op_next;
    logic [lkvc_pkg::KEY_W-1:0] key_reg, key_next;
    logic [lkvc_pkg::VAL_W-1:0] val_reg, val_next;

    // Entry store.
    logic [lkvc_pkg::KEY_W-1:0]  ekey_reg  [N];
    logic [lkvc_pkg::KEY_W-1:0]  ekey_next [N];
    logic [lkvc_pkg::VAL_W-1:0]  eval_reg  [N];
    logic [lkvc_pkg::VAL_W-1:0]  eval_next [N];
    logic [N-1:0]                valid_reg, valid_next;
    logic [lkvc_pkg::RANK_W-1:0] rank_reg  [N];
    logic [lkvc_pkg::RANK_W-1:0] rank_next [N];
    logic [lkvc_pkg::CNT_W-1:0]  fill_reg, fill_next;

    // Lookup results.
    logic                        found_reg, found_next;
    logic                        room_reg, room_next;
    logic [lkvc_pkg::IDX_W-1:0]  hit_slot_reg, hit_slot_next;
    logic [lkvc_pkg::IDX_W-1:0]  free_slot_reg, free_slot_next;
    logic [lkvc_pkg::IDX_W-1:0]  lru_slot_reg, lru_slot_next;

    // Result register.
    logic                       mvalid_reg, mvalid_next;
    logic                       mhit_reg, mhit_next;
    logic [lkvc_pkg::VAL_W-1:0] mval_reg, mval_next;

    logic [lkvc_pkg::CNT_W-1:0]  eff_cap;
    logic [lkvc_pkg::RANK_W-1:0] oldest_rank;
    logic [lkvc_pkg::IDX_W-1:0]  slot;
    logic [lkvc_pkg::RANK_W-1:0] old_rank;
    logic                        age_all;
    logic                        touch;
    logic                        write_entry;

    assign sts.op_get    = (op_reg == lkvc_pkg::OP_GET);
    assign sts.out_stall = mvalid_reg && !m_tready;

    assign m_tvalid  = mvalid_reg;
    assign out_hit   = mhit_reg;
    assign out_value = mval_reg;

    // Zero counts as one, anything above the entry count as the entry count.
    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = lkvc_pkg::CNT_W'(1);
        end else if (lkvc_pkg::CNT_W'(cap_reg) > lkvc_pkg::CNT_W'(N)) begin
            eff_cap = lkvc_pkg::CNT_W'(N);
        end else begin
            eff_cap = lkvc_pkg::CNT_W'(cap_reg);
        end
    end

    assign oldest_rank = lkvc_pkg::RANK_W'(fill_reg - lkvc_pkg::CNT_W'(1));

    // Lookup step: parallel compare and lowest-index selection.
    always_comb begin
        found_next     = found_reg;
        room_next      = room_reg;
        hit_slot_next  = hit_slot_reg;
        free_slot_next = free_slot_reg;
        lru_slot_next  = lru_slot_reg;
        if (cmd.lookup) begin
            found_next     = 1'b0;
            hit_slot_next  = '0;
            free_slot_next = '0;
            lru_slot_next  = '0;
            room_next      = (fill_reg < eff_cap);
            for (int i = N - 1; i >= 0; i--) begin
                if (valid_reg[i] && (ekey_reg[i] == key_reg)) begin
                    found_next    = 1'b1;
                    hit_slot_next = lkvc_pkg::IDX_W'(i);
                end
                if (!valid_reg[i]) begin
                    free_slot_next = lkvc_pkg::IDX_W'(i);
                end
                if (valid_reg[i] && (rank_reg[i] == oldest_rank)) begin
                    lru_slot_next = lkvc_pkg::IDX_W'(i);
                end
            end
        end
    end

    // Commit step: pick the slot, write it and age the newer entries.
    always_comb begin
        priority if (found_reg) begin
            slot    = hit_slot_reg;
            age_all = 1'b0;
        end else if (room_reg) begin
            slot    = free_slot_reg;
            age_all = 1'b1;
        end else begin
            slot    = lru_slot_reg;
            age_all = 1'b0;
        end
        old_rank    = rank_reg[slot];
        write_entry = cmd.commit && (op_reg == lkvc_pkg::OP_PUT);
        touch       = cmd.commit && (found_reg || (op_reg == lkvc_pkg::OP_PUT));
    end

    always_comb begin
        cap_next  = cfg_we ? cfg_wdata : cap_reg;
        op_next   = cmd.capture ? in_op : op_reg;
        key_next  = cmd.capture ? in_key : key_reg;
        val_next  = cmd.capture ? in_value : val_reg;
        fill_next = fill_reg;
        valid_next = valid_reg;
        for (int i = 0; i < N; i++) begin
            ekey_next[i] = ekey_reg[i];
            eval_next[i] = eval_reg[i];
            rank_next[i] = rank_reg[i];
        end
        if (touch) begin
            for (int i = 0; i < N; i++) begin
                if ((lkvc_pkg::IDX_W'(i) != slot) && valid_reg[i]
                        && (age_all || (rank_reg[i] < old_rank))) begin
                    rank_next[i] = rank_reg[i] + lkvc_pkg::RANK_W'(1);
                end
            end
            rank_next[slot] = '0;
        end
        if (write_entry) begin
            eval_next[slot] = val_reg;
            if (!found_reg) begin
                ekey_next[slot]  = key_reg;
                valid_next[slot] = 1'b1;
                if (room_reg) begin
                    fill_next = fill_reg + lkvc_pkg::CNT_W'(1);
                end
            end
        end

        mhit_next = mhit_reg;
        mval_next = mval_reg;
        if (cmd.commit && (op_reg == lkvc_pkg::OP_GET)) begin
            mvalid_next = 1'b1;
            mhit_next   = found_reg;
            mval_next   = found_reg ? eval_reg[hit_slot_reg] : '0;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end else begin
            mvalid_next = mvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg    <= lkvc_pkg::CAP_W'(lkvc_pkg::ENTRIES);
            valid_reg  <= '0;
            fill_reg   <= '0;
            mvalid_reg <= 1'b0;
            for (int i = 0; i < N; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            cap_reg    <= cap_next;
            valid_reg  <= valid_next;
            fill_reg   <= fill_next;
            mvalid_reg <= mvalid_next;
            for (int i = 0; i < N; i++) begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        val_reg       <= val_next;
        found_reg     <= found_next;
        room_reg      <= room_next;
        hit_slot_reg  <= hit_slot_next;
        free_slot_reg <= free_slot_next;
        lru_slot_reg  <= lru_slot_next;
        mhit_reg      <= mhit_next;
        mval_reg      <= mval_next;
        for (int i = 0; i < N; i++) begin
            ekey_reg[i] <= ekey_next[i];
            eval_reg[i] <= eval_next[i];
        end
    end

endmodule

FILE: design/lru_key_value_cache_core.sv
// LRU key-value cache, top level. Each item passes three steps: accept, a
// lookup step that compares all keys in parallel, and a commit step that
// writes the entry of a put and updates the recency ranks. A get result is
// in the output register in the cycle after the commit. No new item is taken
// until the last has committed. Synchronous active-low reset clears valid
// bits, ranks, the fill count and the result register, and sets the capacity
// to 16. Depends on lkvc_pkg, lkvc_ctrl and lkvc_dp.
module lru_key_value_cache_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Capacity register write.
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    // Request items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // key [31:0], value [63:32]
    input  logic [0:0]  s_tuser,   // operation [0]: 0 get, 1 put
    // Result items, one for each get.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_value [31:0]
    output logic [0:0]  m_tuser    // hit [0]
);

    // The controller steps each item through lookup and commit, and holds a
    // get in the commit step while the result register is still full.
    lkvc_pkg::dp_cmd_t cmd;
    lkvc_pkg::dp_sts_t sts;
    logic              hit;

    lkvc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the entries, the per-entry recency ranks (zero is
    // the most recent), the fill count and the result register.
    lkvc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_op     (s_tuser[0]),
        .in_key    (s_tdata[31:0]),
        .in_value  (s_tdata[63:32]),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .out_hit   (hit),
        .out_value (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

    assign m_tuser = hit;

endmodule
